### rtl/core/wmhr_pkg.sv
// Shared types, widths and codes of the weighted mean and height range unit.
package wmhr_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned NormW    = 16;
  localparam int unsigned WeightW  = 24;
  localparam int unsigned WsumW    = 32;
  localparam int unsigned ProdW    = 2 * WsumW;
  localparam int unsigned DenW     = WsumW + 1;
  localparam int unsigned QuotW    = ProdW - WsumW;
  localparam int unsigned DivSteps = QuotW;

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_RANGE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CH_X,
    CH_Y,
    CH_NX,
    CH_NY
  } chan_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_DIV,
    ST_DIV_WAIT,
    ST_STORE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [0:0]               command;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic [WeightW-1:0]       weight;
    logic signed [CoordW-1:0] height_low;
    logic signed [CoordW-1:0] height_high;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] mean_x;
    logic signed [CoordW-1:0] mean_y;
    logic signed [NormW-1:0]  mean_normal_x;
    logic signed [NormW-1:0]  mean_normal_y;
    logic [WsumW-1:0]         weight_sum;
    logic signed [CoordW-1:0] low_height;
    logic signed [CoordW-1:0] high_height;
    logic [0:0]               height_known;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Magnitude of a two's complement word; the most negative value maps to 2**(W-1).
  function automatic logic [CoordW-1:0] mag32(logic signed [CoordW-1:0] v);
    logic [CoordW-1:0] u;
    u = v;
    return v[CoordW-1] ? (~u + CoordW'(1)) : u;
  endfunction

endpackage

### rtl/core/wmhr_stream_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface wmhr_in_if;
  import wmhr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wmhr_out_if;
  import wmhr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/wmhr_div.sv
// Radix-2 restoring divider: one quotient bit per cycle.
module wmhr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wmhr_pkg::ProdW-1:0] dividend_i,
  input  logic [wmhr_pkg::DenW-1:0]  divisor_i,
  output logic [wmhr_pkg::QuotW-1:0] quotient_o,
  output wmhr_pkg::div_stat_t        stat_o
);
  import wmhr_pkg::*;

  localparam int unsigned CntW = $clog2(DivSteps);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [DenW-1:0]   rem_q, rem_d;
  logic [DenW-1:0]   den_q;
  logic [QuotW-1:0]  low_q;
  logic [QuotW-1:0]  quot_q;
  logic [DenW:0]     shifted;
  logic [DenW+1:0]   diff;
  logic              fits;

  // Remainder stays below the divisor, so the shifted value fits DenW+1 bits.
  always_comb begin
    shifted = {rem_q, low_q[QuotW-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    fits    = ~diff[DenW+1];
    rem_d   = fits ? diff[DenW-1:0] : shifted[DenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quot_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivSteps - 1);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CntW'(1);
      quot_q <= {quot_q[QuotW-2:0], fits};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DenW'(dividend_i[ProdW-1:QuotW]);
      low_q <= dividend_i[QuotW-1:0];
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      low_q  <= {low_q[QuotW-2:0], 1'b0};
    end
  end

  assign quotient_o  = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == '0);

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < den_q))
    else $error("partial remainder not below divisor");

  a_quot_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !start_i) |=> $stable(quot_q))
    else $error("quotient changed while idle");
`endif

endmodule

### rtl/core/weighted_mean_and_height_range_unit.sv
// Top level of the weighted mean and height range unit for one grid cell.
//
// Usage:
//   in_i carries one beat per item: a point sample (command 0) or a height
//   range (command 1). out_o returns one beat per item with the statistics
//   after that item: means, saturating weight sum and the height range union.
//   Both channels move a beat when valid and ready are high at a clock edge.
// Sequencing:
//   A point sample runs four blends (x, y, normal x, normal y) through one
//   shared 32x32 multiplier and one radix-2 divider. Each blend steps
//   through two multiplies, a combine, a divider load, the divide steps
//   (one per quotient bit) and a write back. A range item passes through
//   the range update and then emits its result; a sample whose total
//   weight stays zero skips the blends and goes straight to emit. in_i.ready
//   is high only between items, so a new item waits until the last is done.
// Reset and stall:
//   rst_ni clears all statistics to zero and marks the range unknown. A
//   result sits in the output register until taken; the next item is still
//   accepted meanwhile, and its own result waits until that register frees.
module weighted_mean_and_height_range_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  wmhr_in_if.sink    in_i,
  wmhr_out_if.source out_o
);
  import wmhr_pkg::*;

  localparam logic signed [DenW-1:0] Hi32 = 33'sh0_7FFF_FFFF;
  localparam logic signed [DenW-1:0] Lo32 = 33'sh1_8000_0000;
  localparam logic signed [DenW-1:0] Hi16 = 33'sh0_0000_7FFF;
  localparam logic signed [DenW-1:0] Lo16 = 33'sh1_FFFF_8000;

  state_e state_q, state_d;

  // Cell statistics.
  logic signed [CoordW-1:0] mean_x_q, mean_y_q;
  logic signed [NormW-1:0]  nrm_x_q, nrm_y_q;
  logic [WsumW-1:0]         wsum_q;
  logic signed [CoordW-1:0] low_q, high_q;
  logic                     known_q;

  // Working registers of the current item.
  in_item_t         item_q;
  chan_e            ch_q;
  logic [DenW-1:0]  den_q;
  logic [ProdW-1:0] a_q, b_q, m_q;
  logic             neg_q;

  out_item_t out_q;
  logic      out_valid_q;

  logic [DenW-1:0]          den_in;
  logic signed [CoordW-1:0] mean_sel, samp_sel;
  logic [CoordW-1:0]        mul_a, mul_b;
  logic [ProdW-1:0]         prod;
  logic [ProdW-1:0]         sum_ab, d_ba;
  logic [ProdW:0]           d_ab;
  logic [ProdW-1:0]         m_d;
  logic                     neg_d;
  logic [QuotW-1:0]         quot;
  logic signed [DenW-1:0]   blend;
  logic signed [CoordW-1:0] blend32;
  logic signed [NormW-1:0]  blend16;
  logic                     range_ok;
  logic                     div_start;
  div_stat_t                div_stat;
  logic                     emit_go;

  assign den_in = {1'b0, wsum_q} + DenW'(in_i.data.weight);

  // Pick the running mean and the new sample value of the current channel.
  always_comb begin
    unique case (ch_q)
      CH_X: begin
        mean_sel = mean_x_q;
        samp_sel = item_q.point_x;
      end
      CH_Y: begin
        mean_sel = mean_y_q;
        samp_sel = item_q.point_y;
      end
      CH_NX: begin
        mean_sel = CoordW'(nrm_x_q);
        samp_sel = CoordW'(item_q.normal_x);
      end
      default: begin
        mean_sel = CoordW'(nrm_y_q);
        samp_sel = CoordW'(item_q.normal_y);
      end
    endcase
  end

  // Shared multiplier: |mean| * W first, then |sample| * w.
  always_comb begin
    if (state_q == ST_MUL_A) begin
      mul_a = mag32(mean_sel);
      mul_b = wsum_q;
    end else begin
      mul_a = mag32(samp_sel);
      mul_b = CoordW'(item_q.weight);
    end
    prod = ProdW'(mul_a) * ProdW'(mul_b);
  end

  // Signed sum of the two products as sign and magnitude.
  always_comb begin
    sum_ab = a_q + b_q;
    d_ab   = {1'b0, a_q} - {1'b0, b_q};
    d_ba   = b_q - a_q;
    if (mean_sel[CoordW-1] == samp_sel[CoordW-1]) begin
      m_d   = sum_ab;
      neg_d = mean_sel[CoordW-1];
    end else if (!d_ab[ProdW]) begin
      m_d   = d_ab[ProdW-1:0];
      neg_d = mean_sel[CoordW-1];
    end else begin
      m_d   = d_ba;
      neg_d = samp_sel[CoordW-1];
    end
  end

  // Apply the sign, then clamp to the channel's range.
  always_comb begin
    blend = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    if (blend > Hi32) begin
      blend32 = Hi32[CoordW-1:0];
    end else if (blend < Lo32) begin
      blend32 = Lo32[CoordW-1:0];
    end else begin
      blend32 = blend[CoordW-1:0];
    end
    if (blend > Hi16) begin
      blend16 = Hi16[NormW-1:0];
    end else if (blend < Lo16) begin
      blend16 = Lo16[NormW-1:0];
    end else begin
      blend16 = blend[NormW-1:0];
    end
  end

  assign range_ok = (item_q.height_low <= item_q.height_high);

  wmhr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (m_q),
    .divisor_i  (den_q),
    .quotient_o (quot),
    .stat_o     (div_stat)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.data.command == CMD_RANGE) begin
            state_d = ST_RANGE;
          end else if (den_in == '0) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_MUL_A;
          end
        end
      end
      ST_RANGE:    state_d = ST_EMIT;
      ST_MUL_A:    state_d = ST_MUL_B;
      ST_MUL_B:    state_d = ST_SUM;
      ST_SUM:      state_d = ST_DIV;
      ST_DIV:      state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE:    state_d = (ch_q == CH_NY) ? ST_EMIT : ST_MUL_A;
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Handshake and control outputs.
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    div_start   = (state_q == ST_DIV);
    emit_go     = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
    out_o.valid = out_valid_q;
    out_o.data  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ch_q        <= CH_X;
      mean_x_q    <= '0;
      mean_y_q    <= '0;
      nrm_x_q     <= '0;
      nrm_y_q     <= '0;
      wsum_q      <= '0;
      low_q       <= '0;
      high_q      <= '0;
      known_q     <= 1'b0;
    end else begin
      state_q <= state_d;

      // Hold a result until taken; load the next one as the slot frees.
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (in_i.valid && in_i.ready) begin
        ch_q <= CH_X;
      end

      // Write back one channel; the weight sum moves only after the last one.
      if (state_q == ST_STORE) begin
        unique case (ch_q)
          CH_X:    mean_x_q <= blend32;
          CH_Y:    mean_y_q <= blend32;
          CH_NX:   nrm_x_q  <= blend16;
          default: begin
            nrm_y_q <= blend16;
            wsum_q  <= den_q[WsumW] ? '1 : den_q[WsumW-1:0];
          end
        endcase
        ch_q <= chan_e'(ch_q + 2'd1);
      end

      // Copy the first valid range, widen the union after that; drop inverted ranges.
      if (state_q == ST_RANGE && range_ok) begin
        if (!known_q) begin
          low_q   <= item_q.height_low;
          high_q  <= item_q.height_high;
          known_q <= 1'b1;
        end else begin
          if (item_q.height_low < low_q) begin
            low_q <= item_q.height_low;
          end
          if (item_q.height_high > high_q) begin
            high_q <= item_q.height_high;
          end
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
      den_q  <= den_in;
    end
    if (state_q == ST_MUL_A) begin
      a_q <= prod;
    end
    if (state_q == ST_MUL_B) begin
      b_q <= prod;
    end
    if (state_q == ST_SUM) begin
      m_q   <= m_d;
      neg_q <= neg_d;
    end
    if (emit_go) begin
      out_q.mean_x        <= mean_x_q;
      out_q.mean_y        <= mean_y_q;
      out_q.mean_normal_x <= nrm_x_q;
      out_q.mean_normal_y <= nrm_y_q;
      out_q.weight_sum    <= wsum_q;
      out_q.low_height    <= low_q;
      out_q.high_height   <= high_q;
      out_q.height_known  <= known_q;
    end
  end

`ifndef SYNTHESIS
  a_wsum_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wsum_q >= $past(wsum_q))
    else $error("weight sum decreased");

  a_range_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    known_q |-> (low_q <= high_q))
    else $error("height range union inverted");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV_WAIT))
    else $error("divider finished with no blend waiting");
`endif

endmodule
